[design/hsvc_pkg.sv]
// shared constants and pipeline stage types for the hsv to rgb converter
package hsvc_pkg;

  localparam int HueW         = 9;
  localparam int ChanW        = 8;
  localparam int DegPerSector = 60;
  localparam int RemShift     = 2;
  localparam int FullScale    = 255;
  localparam int FracShift    = 8;
  // highest sector boundary a 9-bit hue can reach
  localparam int NumBound     = ((1 << HueW) - 1) / DegPerSector;
  localparam int LastSector   = 5;

  typedef enum logic [2:0] {
    SECTOR_0,
    SECTOR_1,
    SECTOR_2,
    SECTOR_3,
    SECTOR_4,
    SECTOR_5
  } sector_t;

  typedef logic [ChanW-1:0] chan_t;

  typedef struct packed {
    logic    grey;
    sector_t sector;
    chan_t   rem;
    chan_t   sat;
    chan_t   lvl;
  } s1_t;

  typedef struct packed {
    logic    grey;
    sector_t sector;
    chan_t   lvl;
    chan_t   p;
    chan_t   sr;
    chan_t   st;
  } s2_t;

  typedef struct packed {
    logic    grey;
    sector_t sector;
    chan_t   lvl;
    chan_t   p;
    chan_t   q;
    chan_t   t;
  } s3_t;

endpackage

[design/hsvc_sector.sv]
// hue to sector and scaled remainder decode, first pipeline stage logic
module hsvc_sector
  import hsvc_pkg::*;
(
  input  logic [HueW-1:0] hue,
  input  chan_t           saturation,
  input  chan_t           level,
  output s1_t             dec
);

  logic [3:0]      count;
  logic [HueW-1:0] base;
  logic [HueW-1:0] rem;

  // independent boundary compares, the highest one passed sets the base
  always_comb begin
    count = '0;
    base  = '0;
    for (int j = 1; j <= NumBound; j++) begin
      if (hue >= HueW'(j * DegPerSector)) begin
        count = 4'(j);
        base  = HueW'(j * DegPerSector);
      end
    end
  end

  assign rem = hue - base;

  always_comb begin
    dec.grey = (saturation == '0);
    // sectors past the last one share its mapping
    if (count >= 4'(LastSector)) begin
      dec.sector = SECTOR_5;
    end else begin
      dec.sector = sector_t'(count[2:0]);
    end
    dec.rem = ChanW'(rem << RemShift);
    dec.sat = saturation;
    dec.lvl = level;
  end

endmodule

[design/hsv_to_rgb_converter.sv]
// hsv to rgb converter top level: four-stage pipeline with valid/ready channels
//
// usage: present in_hue (degrees), in_saturation and in_level with in_valid;
// an item is taken on a clock edge where in_valid and in_ready are both high.
// the red, green and blue result appears on out_red/out_green/out_blue with
// out_valid and is taken when out_ready is high on the same edge.
// an accepted item passes through sector decode, first products, second products
// and channel select into the output register, where out_valid then rises.
// throughput: one item per cycle while the output is not stalled; every stage holds one item.
// the pipeline advances as a whole whenever the output register is empty
// or being emptied, so in_ready follows out_ready while the output holds an item;
// a stall freezes every stage in place, nothing is dropped or repeated.
// stages holding no item (bubbles) advance and freeze with the rest, so
// bubbles are never squeezed out of the pipe.
// reset (rst_n low, synchronous) clears all valid bits; no item is lost
// or invented afterwards and the block is ready at once.
module hsv_to_rgb_converter
  import hsvc_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [HueW-1:0] in_hue,
  input  chan_t           in_saturation,
  input  chan_t           in_level,
  output logic            out_valid,
  input  logic            out_ready,
  output chan_t           out_red,
  output chan_t           out_green,
  output chan_t           out_blue
);

  logic  adv;
  s1_t   dec;
  s1_t   s1_r;
  s2_t   s2_r, s2_nxt;
  s3_t   s3_r, s3_nxt;
  logic  v1_r, v2_r, v3_r, vo_r;
  chan_t red_r, green_r, blue_r;
  chan_t red_nxt, green_nxt, blue_nxt;

  logic [2*ChanW-1:0] prod_p, prod_sr, prod_st, prod_q, prod_t;

  assign adv      = !vo_r || out_ready;
  assign in_ready = adv;

  hsvc_sector u_sector (
    .hue        (in_hue),
    .saturation (in_saturation),
    .level      (in_level),
    .dec        (dec)
  );

  // stage 2: p and the two saturation-remainder terms
  always_comb begin
    prod_p  = (2*ChanW)'(s1_r.lvl) * (2*ChanW)'(chan_t'(FullScale) - s1_r.sat);
    prod_sr = (2*ChanW)'(s1_r.sat) * (2*ChanW)'(s1_r.rem);
    prod_st = (2*ChanW)'(s1_r.sat) * (2*ChanW)'(chan_t'(FullScale) - s1_r.rem);
    s2_nxt.grey   = s1_r.grey;
    s2_nxt.sector = s1_r.sector;
    s2_nxt.lvl    = s1_r.lvl;
    s2_nxt.p      = ChanW'(prod_p >> FracShift);
    s2_nxt.sr     = ChanW'(prod_sr >> FracShift);
    s2_nxt.st     = ChanW'(prod_st >> FracShift);
  end

  // stage 3: q and t
  always_comb begin
    prod_q = (2*ChanW)'(s2_r.lvl) * (2*ChanW)'(chan_t'(FullScale) - s2_r.sr);
    prod_t = (2*ChanW)'(s2_r.lvl) * (2*ChanW)'(chan_t'(FullScale) - s2_r.st);
    s3_nxt.grey   = s2_r.grey;
    s3_nxt.sector = s2_r.sector;
    s3_nxt.lvl    = s2_r.lvl;
    s3_nxt.p      = s2_r.p;
    s3_nxt.q      = ChanW'(prod_q >> FracShift);
    s3_nxt.t      = ChanW'(prod_t >> FracShift);
  end

  // stage 4: channel select per sector
  always_comb begin
    if (s3_r.grey) begin
      red_nxt   = s3_r.lvl;
      green_nxt = s3_r.lvl;
      blue_nxt  = s3_r.lvl;
    end else begin
      case (s3_r.sector)
        SECTOR_0: begin
          red_nxt = s3_r.lvl; green_nxt = s3_r.t;   blue_nxt = s3_r.p;
        end
        SECTOR_1: begin
          red_nxt = s3_r.q;   green_nxt = s3_r.lvl; blue_nxt = s3_r.p;
        end
        SECTOR_2: begin
          red_nxt = s3_r.p;   green_nxt = s3_r.lvl; blue_nxt = s3_r.t;
        end
        SECTOR_3: begin
          red_nxt = s3_r.p;   green_nxt = s3_r.q;   blue_nxt = s3_r.lvl;
        end
        SECTOR_4: begin
          red_nxt = s3_r.t;   green_nxt = s3_r.p;   blue_nxt = s3_r.lvl;
        end
        default: begin
          red_nxt = s3_r.lvl; green_nxt = s3_r.p;   blue_nxt = s3_r.q;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      vo_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r    <= dec;
      s2_r    <= s2_nxt;
      s3_r    <= s3_nxt;
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_valid = vo_r;
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

endmodule

[dv/tb_hsv_to_rgb_converter.sv]
// self-checking testbench for the hsv to rgb converter with random throttling on both channels
module tb_hsv_to_rgb_converter;
  import hsvc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [HueW-1:0] hue;
    chan_t           sat;
    chan_t           lvl;
    chan_t           red;
    chan_t           green;
    chan_t           blue;
  } color_job_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  logic [HueW-1:0] in_hue = '0;
  chan_t           in_saturation = '0;
  chan_t           in_level = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  chan_t           out_red;
  chan_t           out_green;
  chan_t           out_blue;

  logic            throttle = 1'b1;
  color_job_t      rgb_pending[$];
  int              mismatches = 0;

  hsv_to_rgb_converter dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_hue        (in_hue),
    .in_saturation (in_saturation),
    .in_level      (in_level),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // upper byte of an 8x8 product
  function automatic chan_t frac_mul(input chan_t a, input chan_t b);
    logic [2*ChanW-1:0] prod;
    prod = {{ChanW{1'b0}}, a} * {{ChanW{1'b0}}, b};
    return prod[2*ChanW-1:FracShift];
  endfunction

  function automatic color_job_t rgb_of(input logic [HueW-1:0] hue, input chan_t sat,
                                        input chan_t lvl);
    color_job_t  job;
    int unsigned sec;
    sector_t     sector;
    chan_t       rem;
    chan_t       p;
    chan_t       q;
    chan_t       t;
    job.hue = hue;
    job.sat = sat;
    job.lvl = lvl;
    if (sat == '0) begin
      job.red   = lvl;
      job.green = lvl;
      job.blue  = lvl;
      return job;
    end
    sec    = hue / DegPerSector;
    rem    = chan_t'((hue % DegPerSector) << RemShift);
    // hue 300 and up, including the out-of-range 360..511, share the last mapping
    sector = (sec >= LastSector) ? SECTOR_5 : sector_t'(sec[2:0]);
    p = frac_mul(lvl, chan_t'(FullScale) - sat);
    q = frac_mul(lvl, chan_t'(FullScale) - frac_mul(sat, rem));
    t = frac_mul(lvl, chan_t'(FullScale) - frac_mul(sat, chan_t'(FullScale) - rem));
    case (sector)
      SECTOR_0: begin
        job.red = lvl; job.green = t;   job.blue = p;
      end
      SECTOR_1: begin
        job.red = q;   job.green = lvl; job.blue = p;
      end
      SECTOR_2: begin
        job.red = p;   job.green = lvl; job.blue = t;
      end
      SECTOR_3: begin
        job.red = p;   job.green = q;   job.blue = lvl;
      end
      SECTOR_4: begin
        job.red = t;   job.green = p;   job.blue = lvl;
      end
      default: begin
        job.red = lvl; job.green = p;   job.blue = q;
      end
    endcase
    return job;
  endfunction

  // mostly uniform, with the extremes showing up often
  function automatic chan_t pick_chan();
    int unsigned roll;
    roll = $urandom_range(9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return chan_t'($urandom_range(255));
  endfunction

  task automatic send_color(input logic [HueW-1:0] hue, input chan_t sat, input chan_t lvl);
    // each cycle idles with the same odds
    while (throttle && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_hue        <= hue;
    in_saturation <= sat;
    in_level      <= lvl;
    do @(posedge clk); while (!in_ready);
    rgb_pending.push_back(rgb_of(hue, sat, lvl));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (rgb_pending.size() != 0) @(posedge clk);
  endtask

  // result side: random stalls and in-order comparison
  always @(posedge clk) begin
    color_job_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(throttle && $urandom_range(99) < 32);
      if (out_valid && out_ready) begin
        if (rgb_pending.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected item: rgb %0d %0d %0d", out_red, out_green, out_blue);
          mismatches++;
        end else begin
          want = rgb_pending.pop_front();
          if (out_red !== want.red || out_green !== want.green || out_blue !== want.blue) begin
            if (mismatches < 10)
              $display("mismatch hsv %0d/%0d/%0d: exp rgb %0d %0d %0d got %0d %0d %0d",
                       want.hue, want.sat, want.lvl, want.red, want.green, want.blue,
                       out_red, out_green, out_blue);
            mismatches++;
          end
        end
      end
    end
  end

  task automatic test_directed();
    send_color(9'd0,   8'd255, 8'd255);
    send_color(9'd59,  8'd255, 8'd255);
    send_color(9'd60,  8'd255, 8'd255);
    send_color(9'd119, 8'd200, 8'd255);
    send_color(9'd120, 8'd255, 8'd128);
    send_color(9'd179, 8'd1,   8'd255);
    send_color(9'd180, 8'd255, 8'd255);
    send_color(9'd239, 8'd128, 8'd200);
    send_color(9'd240, 8'd255, 8'd255);
    send_color(9'd299, 8'd255, 8'd1);
    send_color(9'd300, 8'd255, 8'd255);
    send_color(9'd359, 8'd255, 8'd255);
    // hue beyond the circle
    send_color(9'd360, 8'd255, 8'd255);
    send_color(9'd419, 8'd100, 8'd200);
    send_color(9'd420, 8'd255, 8'd255);
    send_color(9'd479, 8'd77,  8'd255);
    send_color(9'd480, 8'd255, 8'd255);
    send_color(9'd511, 8'd255, 8'd255);
    // grey and dark colours; hue is ignored where saturation is zero
    send_color(9'd511, 8'd0,   8'd37);
    send_color(9'd0,   8'd0,   8'd255);
    send_color(9'd200, 8'd0,   8'd0);
    send_color(9'd100, 8'd255, 8'd0);
    send_color(9'd45,  8'd1,   8'd1);
  endtask

  task automatic test_nominal_hue();
    repeat (600) send_color(9'($urandom_range(359)), pick_chan(), pick_chan());
  endtask

  task automatic test_sector_boundaries();
    int unsigned sec;
    int unsigned hue_pick;
    repeat (200) begin
      sec = $urandom_range(8);
      hue_pick = sec * DegPerSector + ($urandom_range(1) ? DegPerSector - 1 : 0);
      // the last sector is cut short by the port width
      if (hue_pick > (1 << HueW) - 1) hue_pick = (1 << HueW) - 1;
      send_color(9'(hue_pick), pick_chan(), pick_chan());
    end
  endtask

  task automatic test_full_rate();
    throttle <= 1'b0;
    repeat (300) send_color(9'($urandom_range(511)), pick_chan(), pick_chan());
    throttle <= 1'b1;
  endtask

  task automatic test_wide_hue();
    repeat (200) send_color(9'($urandom_range(511, 360)), pick_chan(), pick_chan());
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_nominal_hue();
    drain_results();
    test_sector_boundaries();
    test_full_rate();
    test_wide_hue();
    drain_results();
    repeat (8) @(posedge clk);
    if (rgb_pending.size() != 0) begin
      $display("%0d expected items never arrived", rgb_pending.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("hsv_to_rgb_converter regression: pass");
    end else begin
      $display("hsv_to_rgb_converter regression: fail");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("hsv_to_rgb_converter regression: fail");
    $finish;
  end

endmodule

[filelist.f]
design/hsvc_pkg.sv
design/hsvc_sector.sv
design/hsv_to_rgb_converter.sv
dv/tb_hsv_to_rgb_converter.sv
